/* hw/rtl/value_list_mean_median_assert.svh */
// Assertion macros shared by the value list checker.
`ifndef VALUE_LIST_MEAN_MEDIAN_ASSERT_SVH
`define VALUE_LIST_MEAN_MEDIAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VLMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VLMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vlmm_pkg.sv */
// Package with operation codes, status codes and sequencer states of the value list.
`timescale 1ns / 1ps

package vlmm_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes of a result word
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_INS,
        SQ_SHF,
        SQ_DEL,
        SQ_STAT,
        SQ_DIV,
        SQ_MED0,
        SQ_MED1,
        SQ_MED2,
        SQ_DONE
    } t_state;

endpackage

/* hw/rtl/value_list_mean_median.sv */
// Value list with running sum, serial mean and sorted-shadow median.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | i_opcode, i_value, i_position
//  output  | out       | o_valid / i_ready  | o_status, o_entry_total, o_mean,
//          |           |                    | o_median_doubled
//
//  One word at a time. Append walks the sorted list down from the tail to insert the value,
//  remove shifts the order memory from the position and then closes the gap in the sorted
//  memory, then every word on a non-empty list runs the restoring divider and the median reads.
//  Reset is synchronous, active low; both memories need no clearing pass.
//  The result sits in an output register, so a stalled output holds only the
//  finishing step while the next word may already be accepted.
`timescale 1ns / 1ps

module value_list_mean_median #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_opcode,
    input  logic [VALUE_BITS-1:0]                 i_value,
    input  logic [$clog2(CAPACITY)-1:0]           i_position,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_status,
    output logic [$clog2(CAPACITY+1)-1:0]         o_entry_total,
    output logic [VALUE_BITS-1:0]                 o_mean,
    output logic [VALUE_BITS:0]                   o_median_doubled
);

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int SUM_BITS  = VALUE_BITS + ADDR_BITS + 1;
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    // Order memory and sorted shadow memory
    logic [VALUE_BITS-1:0] r_vs_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_sl_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_vs_q;
    logic [VALUE_BITS-1:0] r_sl_q;

    logic [ADDR_BITS-1:0]  c_vs_raddr, c_vs_waddr, c_sl_raddr, c_sl_waddr;
    logic                  c_vs_we, c_sl_we;
    logic [VALUE_BITS-1:0] c_vs_wdata, c_sl_wdata;

    // Sequencer and list state
    vlmm_pkg::t_state      r_state, n_state;
    logic [CNT_BITS-1:0]   r_count;
    logic [SUM_BITS-1:0]   r_sum;
    logic [VALUE_BITS-1:0] r_val;
    logic [ADDR_BITS-1:0]  r_pos;
    logic [1:0]            r_status;

    // Scan pipeline
    logic [CNT_BITS-1:0]   r_idx;
    logic                  r_pend;
    logic [ADDR_BITS-1:0]  r_paddr;
    logic                  r_found;
    logic                  c_issue, c_done;
    logic [CNT_BITS-1:0]   c_next_idx;
    logic [ADDR_BITS-1:0]  c_issue_addr;

    // Divider and median
    logic [SUM_BITS-1:0]   r_quo;
    logic [CNT_BITS-1:0]   r_rem;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mhi;
    logic [VALUE_BITS:0]   r_med;

    // Output register
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [CNT_BITS-1:0]   r_out_total;
    logic [VALUE_BITS-1:0] r_out_mean;
    logic [VALUE_BITS:0]   r_out_med;

    logic                  w_accept, w_load, w_full, w_bad, w_greater;
    logic [CNT_BITS-1:0]   w_idx_m1, w_pos_ext;
    logic [ADDR_BITS-1:0]  w_mid, w_mid_m1;
    logic [SUM_BITS-1:0]   w_val_ext, w_sum_mag, w_quo_signed;
    logic [CNT_BITS:0]     w_trial, w_trial_sub;
    logic                  w_ge;

    assign o_ready  = (r_state == vlmm_pkg::SQ_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == vlmm_pkg::SQ_DONE) && (!r_out_valid || i_ready);

    assign w_pos_ext = CNT_BITS'(i_position);
    assign w_full    = (r_count == CNT_BITS'(CAPACITY));
    assign w_bad     = (w_pos_ext >= r_count);
    assign w_idx_m1  = r_idx - 1'b1;
    assign w_greater = ($signed(r_sl_q) > $signed(r_val));
    assign w_mid     = ADDR_BITS'(r_count >> 1);
    assign w_mid_m1  = w_mid - 1'b1;
    assign w_val_ext = {{(SUM_BITS - VALUE_BITS){r_val[VALUE_BITS-1]}}, r_val};
    assign w_sum_mag = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;

    // Divider trial subtract
    assign w_trial     = {r_rem, r_quo[SUM_BITS-1]};
    assign w_ge        = (w_trial >= {1'b0, r_count});
    assign w_trial_sub = w_trial - {1'b0, r_count};

    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vlmm_pkg::SQ_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        vlmm_pkg::OP_APPEND: n_state = w_full ? vlmm_pkg::SQ_STAT
                                                              : vlmm_pkg::SQ_INS;
                        vlmm_pkg::OP_REMOVE: n_state = w_bad ? vlmm_pkg::SQ_STAT
                                                             : vlmm_pkg::SQ_SHF;
                        default:             n_state = vlmm_pkg::SQ_STAT;
                    endcase
                end
            end
            vlmm_pkg::SQ_INS:  if (c_done) n_state = vlmm_pkg::SQ_STAT;
            vlmm_pkg::SQ_SHF:  if (c_done) n_state = vlmm_pkg::SQ_DEL;
            vlmm_pkg::SQ_DEL:  if (c_done) n_state = vlmm_pkg::SQ_STAT;
            vlmm_pkg::SQ_STAT: begin
                n_state = (r_count == '0) ? vlmm_pkg::SQ_DONE : vlmm_pkg::SQ_DIV;
            end
            vlmm_pkg::SQ_DIV:  if (r_step == STEP_BITS'(1)) n_state = vlmm_pkg::SQ_MED0;
            vlmm_pkg::SQ_MED0: n_state = vlmm_pkg::SQ_MED1;
            vlmm_pkg::SQ_MED1: n_state = vlmm_pkg::SQ_MED2;
            vlmm_pkg::SQ_MED2: n_state = vlmm_pkg::SQ_DONE;
            vlmm_pkg::SQ_DONE: if (w_load) n_state = vlmm_pkg::SQ_IDLE;
            default:           n_state = vlmm_pkg::SQ_IDLE;
        endcase
    end

    // Memory ports and scan control
    always_comb begin
        c_issue      = 1'b0;
        c_done       = 1'b0;
        c_next_idx   = r_idx;
        c_issue_addr = r_idx[ADDR_BITS-1:0];
        c_vs_raddr   = r_idx[ADDR_BITS-1:0];
        c_sl_raddr   = r_idx[ADDR_BITS-1:0];
        c_vs_we      = 1'b0;
        c_vs_waddr   = r_paddr - 1'b1;
        c_vs_wdata   = r_vs_q;
        c_sl_we      = 1'b0;
        c_sl_waddr   = r_paddr - 1'b1;
        c_sl_wdata   = r_sl_q;
        case (r_state)
            vlmm_pkg::SQ_INS: begin
                // put the value at the tail of the order memory
                c_vs_we      = 1'b1;
                c_vs_waddr   = r_count[ADDR_BITS-1:0];
                c_vs_wdata   = r_val;
                // walk down, move larger entries up one slot, drop the value in
                c_issue      = (r_idx != '0);
                c_next_idx   = w_idx_m1;
                c_issue_addr = w_idx_m1[ADDR_BITS-1:0];
                c_sl_raddr   = w_idx_m1[ADDR_BITS-1:0];
                c_sl_waddr   = r_paddr + 1'b1;
                if (r_pend) begin
                    c_sl_we = 1'b1;
                    if (!w_greater) begin
                        c_sl_wdata = r_val;
                        c_done     = 1'b1;
                    end
                end else if (r_idx == '0) begin
                    c_sl_we    = 1'b1;
                    c_sl_waddr = '0;
                    c_sl_wdata = r_val;
                    c_done     = 1'b1;
                end
            end
            vlmm_pkg::SQ_SHF: begin
                // walk up from the position, move later entries down
                c_issue    = (r_idx < r_count);
                c_next_idx = r_idx + 1'b1;
                c_vs_we    = r_pend && (r_paddr != r_pos);
                c_done     = !r_pend && !c_issue;
            end
            vlmm_pkg::SQ_DEL: begin
                // walk up the sorted list, close the gap after the matching entry
                c_issue    = (r_idx < r_count);
                c_next_idx = r_idx + 1'b1;
                c_sl_we    = r_pend && r_found;
                c_done     = !r_pend && !c_issue;
            end
            vlmm_pkg::SQ_MED0: c_sl_raddr = w_mid;
            vlmm_pkg::SQ_MED1: c_sl_raddr = r_count[0] ? w_mid : w_mid_m1;
            default: ;
        endcase
    end

    // Order memory
    always_ff @(posedge i_clk) begin
        if (c_vs_we) r_vs_mem[c_vs_waddr] <= c_vs_wdata;
        r_vs_q <= r_vs_mem[c_vs_raddr];
    end

    // Sorted memory
    always_ff @(posedge i_clk) begin
        if (c_sl_we) r_sl_mem[c_sl_waddr] <= c_sl_wdata;
        r_sl_q <= r_sl_mem[c_sl_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vlmm_pkg::SQ_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= c_issue && !c_done;
            if (r_state == vlmm_pkg::SQ_INS && c_done) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + w_val_ext;
            end
            if (r_state == vlmm_pkg::SQ_DEL && c_done) begin
                r_count <= r_count - 1'b1;
                r_sum   <= r_sum - w_val_ext;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (c_issue) begin
            r_idx   <= c_next_idx;
            r_paddr <= c_issue_addr;
        end
        case (r_state)
            vlmm_pkg::SQ_IDLE: begin
                // capture the word and seed the scan
                if (w_accept) begin
                    r_val   <= i_value;
                    r_pos   <= i_position;
                    r_found <= 1'b0;
                    if (i_opcode == vlmm_pkg::OP_APPEND) begin
                        r_idx    <= r_count;
                        r_status <= w_full ? vlmm_pkg::STS_FULL : vlmm_pkg::STS_OK;
                    end else begin
                        r_idx    <= w_pos_ext;
                        r_status <= (i_opcode == vlmm_pkg::OP_REMOVE && w_bad)
                                    ? vlmm_pkg::STS_BAD_INDEX : vlmm_pkg::STS_OK;
                    end
                end
            end
            vlmm_pkg::SQ_SHF: begin
                // hold the removed value for the sum and the sorted delete
                if (r_pend && r_paddr == r_pos) r_val <= r_vs_q;
                if (c_done) r_idx <= '0;
            end
            vlmm_pkg::SQ_DEL: begin
                if (r_pend && !r_found && r_sl_q == r_val) r_found <= 1'b1;
            end
            vlmm_pkg::SQ_STAT: begin
                // load the divider, or zero the statistics of an empty list
                r_rem  <= '0;
                r_step <= STEP_BITS'(SUM_BITS);
                if (r_count == '0) begin
                    r_quo <= '0;
                    r_neg <= 1'b0;
                    r_med <= '0;
                end else begin
                    r_quo <= w_sum_mag;
                    r_neg <= r_sum[SUM_BITS-1];
                end
            end
            vlmm_pkg::SQ_DIV: begin
                // one quotient bit per cycle
                r_quo  <= {r_quo[SUM_BITS-2:0], w_ge};
                r_rem  <= w_ge ? w_trial_sub[CNT_BITS-1:0] : w_trial[CNT_BITS-1:0];
                r_step <= r_step - 1'b1;
            end
            vlmm_pkg::SQ_MED1: r_mhi <= r_sl_q;
            vlmm_pkg::SQ_MED2: begin
                if (r_count[0]) begin
                    r_med <= {r_mhi, 1'b0};
                end else begin
                    r_med <= {r_mhi[VALUE_BITS-1], r_mhi} + {r_sl_q[VALUE_BITS-1], r_sl_q};
                end
            end
            vlmm_pkg::SQ_DONE: begin
                if (w_load) begin
                    r_out_status <= r_status;
                    r_out_total  <= r_count;
                    r_out_mean   <= w_quo_signed[VALUE_BITS-1:0];
                    r_out_med    <= r_med;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_total    = r_out_total;
    assign o_mean           = r_out_mean;
    assign o_median_doubled = r_out_med;

endmodule

/* hw/rtl/vlmm_checker.sv */
// Port-level checker for the value list, bound to the top level.
`timescale 1ns / 1ps
`include "value_list_mean_median_assert.svh"

module vlmm_checker #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [1:0]                    o_status,
    input logic [$clog2(CAPACITY+1)-1:0] o_entry_total,
    input logic [VALUE_BITS-1:0]         o_mean,
    input logic [VALUE_BITS:0]           o_median_doubled
);

    // Hold a stalled result word
    `VLMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_entry_total) && $stable(o_mean) && $stable(o_median_doubled), "result word changed while stalled")

    // One word in flight: ready drops after an accept
    `VLMM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready stayed high after an accepted word")

    // Count never exceeds the capacity
    `VLMM_ASSERT_NOW(a_total_range, i_clk, i_rst_n, o_valid, o_entry_total <= ($clog2(CAPACITY+1))'(CAPACITY), "entry count above capacity")

    // Empty list gives zero statistics
    `VLMM_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_valid && o_entry_total == '0, o_mean == '0 && o_median_doubled == '0, "nonzero statistics on an empty list")

    // Full status only at capacity
    `VLMM_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_valid && o_status == vlmm_pkg::STS_FULL, o_entry_total == ($clog2(CAPACITY+1))'(CAPACITY), "full status below capacity")

endmodule

bind value_list_mean_median vlmm_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_vlmm_checker (.*);
